// File: hw/rtl/oilpm_pkg.sv
// Shared types and constants for the oil paint mode filter.
package oilpm_pkg;

    localparam int MAX_HEIGHT = 4096;
    localparam int CFG_W      = 13;
    localparam int IDX_W      = 2;
    localparam int X_W        = 11;
    localparam int Y_W        = 12;
    localparam int PIX_W      = 8;

    localparam logic [IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [IDX_W-1:0] REG_LEVELS = 2'd1;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd2;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd3;

    localparam logic [2:0]  RADIUS_RST = 3'd2;
    localparam logic [7:0]  LEVELS_RST = 8'd10;
    localparam logic [11:0] WIDTH_RST  = 12'd640;
    localparam logic [12:0] HEIGHT_RST = 13'd480;

    // bin = floor(sum * levels / 765), done as reciprocal multiply plus one correction
    localparam int BIN_DIV   = 3 * 255;
    localparam int BIN_SHIFT = 20;
    localparam int BIN_RECIP = (1 << BIN_SHIFT) / BIN_DIV;
    localparam int PROD_W    = 18;
    localparam int MUL_W     = 29;
    localparam int Q_W       = 9;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_MUL,
        ST_PIX_DIV,
        ST_BIN_CALC,
        ST_BIN_RD,
        ST_BIN_WR,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic pix_rd;
        logic pix_mul;
        logic pix_div;
        logic bin_calc;
        logic bin_rd;
        logic bin_wr;
        logic scan_en;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic has_window;
        logic win_last;
        logic scan_last;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// File: hw/rtl/oil_paint_mode_filter.sv
// Top level of the oil paint mode filter: controller plus datapath.
// Pixels enter in raster order, one word per handshake; each interior pixel whose
// (2R+1)x(2R+1) window is complete yields one output word. An input word that
// completes no window leaves the controller ready for the next word. For one that
// completes a window, each window pixel is read from the line store, binned by a
// reciprocal multiply and accumulated into the single-port bin memory in six steps,
// then all bins are scanned once (clearing them on the way) and the winning sums
// go through an 8-step divider. After reset the bin memory is cleared before the
// first pixel is taken; configuration writes are accepted throughout. A finished
// output word waits in its own register, so the next pixel can be taken meanwhile.
module oil_paint_mode_filter #(
    parameter int MAX_RADIUS = 5,
    parameter int MAX_WIDTH  = 2048,
    parameter int NUM_BINS   = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [oilpm_pkg::IDX_W-1:0]  cfg_index,
    input  logic [oilpm_pkg::CFG_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [oilpm_pkg::PIX_W-1:0]  in_red,
    input  logic [oilpm_pkg::PIX_W-1:0]  in_green,
    input  logic [oilpm_pkg::PIX_W-1:0]  in_blue,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [oilpm_pkg::X_W-1:0]    out_x,
    output logic [oilpm_pkg::Y_W-1:0]    out_y,
    output logic [oilpm_pkg::PIX_W-1:0]  out_red,
    output logic [oilpm_pkg::PIX_W-1:0]  out_green,
    output logic [oilpm_pkg::PIX_W-1:0]  out_blue,
    output logic                         frame_last
);

    oilpm_pkg::cmd_t    cmd;
    oilpm_pkg::status_t status;

    oilpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    oilpm_datapath #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .NUM_BINS   (NUM_BINS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .frame_last (frame_last)
    );

endmodule

// File: hw/rtl/oilpm_ctrl.sv
// Sequencer for the oil paint mode filter: window sweep, bin scan, divide, output.
module oilpm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  oilpm_pkg::status_t status,
    output oilpm_pkg::cmd_t   cmd
);

    oilpm_pkg::state_t state_reg;
    oilpm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oilpm_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            oilpm_pkg::ST_CLEAR:
            begin
                if (status.scan_last)
                begin
                    state_next = oilpm_pkg::ST_IDLE;
                end
            end
            oilpm_pkg::ST_IDLE:
            begin
                if (in_valid && status.has_window)
                begin
                    state_next = oilpm_pkg::ST_PIX_RD;
                end
            end
            oilpm_pkg::ST_PIX_RD:    state_next = oilpm_pkg::ST_PIX_MUL;
            oilpm_pkg::ST_PIX_MUL:   state_next = oilpm_pkg::ST_PIX_DIV;
            oilpm_pkg::ST_PIX_DIV:   state_next = oilpm_pkg::ST_BIN_CALC;
            oilpm_pkg::ST_BIN_CALC:  state_next = oilpm_pkg::ST_BIN_RD;
            oilpm_pkg::ST_BIN_RD:    state_next = oilpm_pkg::ST_BIN_WR;
            oilpm_pkg::ST_BIN_WR:
            begin
                state_next = status.win_last ? oilpm_pkg::ST_SCAN : oilpm_pkg::ST_PIX_RD;
            end
            oilpm_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = oilpm_pkg::ST_SCAN_TAIL;
                end
            end
            oilpm_pkg::ST_SCAN_TAIL: state_next = oilpm_pkg::ST_DIV_INIT;
            oilpm_pkg::ST_DIV_INIT:  state_next = oilpm_pkg::ST_DIV;
            oilpm_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = oilpm_pkg::ST_OUT;
                end
            end
            oilpm_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = oilpm_pkg::ST_IDLE;
                end
            end
            default:                 state_next = oilpm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            oilpm_pkg::ST_CLEAR:     cmd.scan_en = 1'b1;
            oilpm_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            oilpm_pkg::ST_PIX_RD:    cmd.pix_rd   = 1'b1;
            oilpm_pkg::ST_PIX_MUL:   cmd.pix_mul  = 1'b1;
            oilpm_pkg::ST_PIX_DIV:   cmd.pix_div  = 1'b1;
            oilpm_pkg::ST_BIN_CALC:  cmd.bin_calc = 1'b1;
            oilpm_pkg::ST_BIN_RD:    cmd.bin_rd   = 1'b1;
            oilpm_pkg::ST_BIN_WR:    cmd.bin_wr   = 1'b1;
            oilpm_pkg::ST_SCAN:      cmd.scan_en  = 1'b1;
            oilpm_pkg::ST_SCAN_TAIL: cmd = '0;
            oilpm_pkg::ST_DIV_INIT:  cmd.div_init = 1'b1;
            oilpm_pkg::ST_DIV:       cmd.div_step = 1'b1;
            oilpm_pkg::ST_OUT:       cmd.out_load = status.out_free;
            default:                 cmd = '0;
        endcase
    end

endmodule

// File: hw/rtl/oilpm_datapath.sv
// Datapath: config, raster counters, line store, bin memory, scan and divider.
module oilpm_datapath #(
    parameter int MAX_RADIUS = 5,
    parameter int MAX_WIDTH  = 2048,
    parameter int NUM_BINS   = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [oilpm_pkg::IDX_W-1:0]      cfg_index,
    input  logic [oilpm_pkg::CFG_W-1:0]      cfg_data,
    input  logic [oilpm_pkg::PIX_W-1:0]      in_red,
    input  logic [oilpm_pkg::PIX_W-1:0]      in_green,
    input  logic [oilpm_pkg::PIX_W-1:0]      in_blue,
    input  oilpm_pkg::cmd_t                  cmd,
    output oilpm_pkg::status_t               status,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [oilpm_pkg::X_W-1:0]        out_x,
    output logic [oilpm_pkg::Y_W-1:0]        out_y,
    output logic [oilpm_pkg::PIX_W-1:0]      out_red,
    output logic [oilpm_pkg::PIX_W-1:0]      out_green,
    output logic [oilpm_pkg::PIX_W-1:0]      out_blue,
    output logic                             frame_last
);

    localparam int LINES    = 2 * MAX_RADIUS + 1;
    localparam int XW       = $clog2(MAX_WIDTH);
    localparam int LW       = $clog2(LINES);
    localparam int RW       = $clog2(MAX_RADIUS + 1);
    localparam int SPW      = $clog2(2 * MAX_RADIUS + 1);
    localparam int BW       = $clog2(NUM_BINS);
    localparam int WIN_MAX  = LINES * LINES;
    localparam int CW       = $clog2(WIN_MAX + 1);
    localparam int SW       = $clog2(WIN_MAX * 255 + 1);
    localparam int BWORD    = CW + 3 * SW;
    localparam int LS_DEPTH = LINES * (1 << XW);
    localparam int HW       = 13;
    localparam int DW       = SW + oilpm_pkg::PIX_W;

    // configuration
    logic [2:0]  radius_reg;
    logic [7:0]  levels_reg;
    logic [11:0] width_reg;
    logic [12:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= oilpm_pkg::RADIUS_RST;
            levels_reg <= oilpm_pkg::LEVELS_RST;
            width_reg  <= oilpm_pkg::WIDTH_RST;
            height_reg <= oilpm_pkg::HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                oilpm_pkg::REG_RADIUS: radius_reg <= cfg_data[2:0];
                oilpm_pkg::REG_LEVELS: levels_reg <= cfg_data[7:0];
                oilpm_pkg::REG_WIDTH:  width_reg  <= cfg_data[11:0];
                oilpm_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [RW-1:0]  rad_eff;
    logic [SPW-1:0] span;
    logic [XW:0]    w_eff;
    logic [HW-1:0]  h_eff;

    always_comb
    begin
        if (32'(radius_reg) > MAX_RADIUS)
            rad_eff = RW'(MAX_RADIUS);
        else
            rad_eff = RW'(radius_reg);
        span = SPW'(2 * 32'(rad_eff));
        if (width_reg == '0)
            w_eff = (XW+1)'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = (XW+1)'(MAX_WIDTH);
        else
            w_eff = (XW+1)'(width_reg);
        if (height_reg == '0)
            h_eff = HW'(1);
        else if (32'(height_reg) > oilpm_pkg::MAX_HEIGHT)
            h_eff = HW'(oilpm_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // raster position
    logic [XW-1:0] cc_reg, cc_next;
    logic [11:0]   rc_reg, rc_next;
    logic [LW-1:0] slot_reg, slot_next;

    logic [XW-1:0] c_cur;
    logic [11:0]   r_cur;
    logic [LW-1:0] s_cur;
    logic [HW-1:0] r_inc;
    logic [LW-1:0] s_inc;
    logic [XW:0]   c_plus;
    logic [HW-1:0] r_plus;
    logic [LW-1:0] s_plus;
    logic          pre_wrap;
    logic [LW:0]   ws_tmp;
    logic [LW-1:0] ws_start;

    always_comb
    begin
        pre_wrap = ({1'b0, cc_reg} >= w_eff);
        c_cur    = pre_wrap ? '0 : cc_reg;
        r_inc    = pre_wrap ? HW'(rc_reg) + HW'(1) : HW'(rc_reg);
        if (pre_wrap)
            s_inc = (32'(slot_reg) == LINES - 1) ? '0 : slot_reg + LW'(1);
        else
            s_inc = slot_reg;
        if (r_inc >= h_eff)
        begin
            r_cur = '0;
            s_cur = '0;
        end
        else
        begin
            r_cur = r_inc[11:0];
            s_cur = s_inc;
        end

        c_plus = (XW+1)'(c_cur) + (XW+1)'(1);
        r_plus = HW'(r_cur) + HW'(1);
        s_plus = (32'(s_cur) == LINES - 1) ? '0 : s_cur + LW'(1);
        if (c_plus >= w_eff)
        begin
            cc_next = '0;
            if (r_plus >= h_eff)
            begin
                rc_next   = '0;
                slot_next = '0;
            end
            else
            begin
                rc_next   = r_plus[11:0];
                slot_next = s_plus;
            end
        end
        else
        begin
            cc_next   = c_plus[XW-1:0];
            rc_next   = r_cur;
            slot_next = s_cur;
        end

        ws_tmp = (LW+1)'(s_cur) + (LW+1)'(LINES) - (LW+1)'(span);
        if (32'(ws_tmp) >= LINES)
            ws_start = LW'(32'(ws_tmp) - LINES);
        else
            ws_start = ws_tmp[LW-1:0];
    end

    assign status.has_window = ((XW+1)'(c_cur) >= (XW+1)'(span)) && (r_cur >= 12'(span));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg   <= '0;
            rc_reg   <= '0;
            slot_reg <= '0;
        end
        else if (cmd.accept)
        begin
            cc_reg   <= cc_next;
            rc_reg   <= rc_next;
            slot_reg <= slot_next;
        end
    end

    // window sweep
    logic [XW-1:0]  wc_reg, wx_reg;
    logic [11:0]    wr_reg;
    logic [RW-1:0]  wrad_reg;
    logic [SPW-1:0] wspan_reg, wk_reg;
    logic [LW-1:0]  wslot_reg;
    logic           wlast_reg;

    assign status.win_last = (wk_reg == wspan_reg) && (wx_reg == wc_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            wc_reg    <= c_cur;
            wr_reg    <= r_cur;
            wrad_reg  <= rad_eff;
            wspan_reg <= span;
            wlast_reg <= ((XW+1)'(c_cur) == w_eff - (XW+1)'(1)) &&
                         (HW'(r_cur) == h_eff - HW'(1));
            wx_reg    <= c_cur - XW'(span);
            wk_reg    <= '0;
            wslot_reg <= ws_start;
        end
        else if (cmd.bin_wr)
        begin
            if (wx_reg == wc_reg)
            begin
                wx_reg    <= wc_reg - XW'(wspan_reg);
                wk_reg    <= wk_reg + SPW'(1);
                wslot_reg <= (32'(wslot_reg) == LINES - 1) ? '0 : wslot_reg + LW'(1);
            end
            else
            begin
                wx_reg <= wx_reg + XW'(1);
            end
        end
    end

    // line store
    logic [3*oilpm_pkg::PIX_W-1:0] ls_mem [0:LS_DEPTH-1];
    logic [3*oilpm_pkg::PIX_W-1:0] ls_q;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            ls_mem[{s_cur, c_cur}] <= {in_blue, in_green, in_red};
        if (cmd.pix_rd)
            ls_q <= ls_mem[{wslot_reg, wx_reg}];
    end

    // binning
    logic [oilpm_pkg::PROD_W-1:0] prod_reg;
    logic [oilpm_pkg::Q_W-1:0]    q0_reg;
    logic [BW-1:0]                bin_reg;
    logic [oilpm_pkg::MUL_W-1:0]  mul_w;
    logic [oilpm_pkg::PROD_W-1:0] rem_w;
    logic [oilpm_pkg::Q_W-1:0]    q1_w;

    always_comb
    begin
        mul_w = oilpm_pkg::MUL_W'(prod_reg) * oilpm_pkg::MUL_W'(oilpm_pkg::BIN_RECIP);
        rem_w = prod_reg - oilpm_pkg::PROD_W'(oilpm_pkg::PROD_W'(q0_reg) *
                                              oilpm_pkg::PROD_W'(oilpm_pkg::BIN_DIV));
        q1_w  = (32'(rem_w) >= oilpm_pkg::BIN_DIV) ? q0_reg + oilpm_pkg::Q_W'(1) : q0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pix_mul)
            prod_reg <= oilpm_pkg::PROD_W'(10'(ls_q[7:0]) + 10'(ls_q[15:8]) + 10'(ls_q[23:16]))
                        * oilpm_pkg::PROD_W'(levels_reg);
        if (cmd.pix_div)
            q0_reg <= oilpm_pkg::Q_W'(mul_w >> oilpm_pkg::BIN_SHIFT);
        if (cmd.bin_calc)
            bin_reg <= (32'(q1_w) > NUM_BINS - 1) ? BW'(NUM_BINS - 1) : BW'(q1_w);
    end

    // bin memory: {count, blue sum, green sum, red sum}
    logic [BWORD-1:0] bin_mem [0:NUM_BINS-1];
    logic [BWORD-1:0] bq;
    logic [BW-1:0]    scan_idx_reg;
    logic [BW-1:0]    bin_addr;
    logic [BWORD-1:0] bin_upd;
    logic             scan_pend_reg;

    assign bin_addr = cmd.scan_en ? scan_idx_reg : bin_reg;
    assign bin_upd  = {bq[BWORD-1 -: CW] + CW'(1),
                       bq[3*SW-1 -: SW] + SW'(ls_q[23:16]),
                       bq[2*SW-1 -: SW] + SW'(ls_q[15:8]),
                       bq[SW-1:0]       + SW'(ls_q[7:0])};
    assign status.scan_last = (32'(scan_idx_reg) == NUM_BINS - 1);

    always_ff @(posedge clk)
    begin
        if (cmd.scan_en || cmd.bin_rd)
            bq <= bin_mem[bin_addr];
        if (cmd.scan_en)
            bin_mem[bin_addr] <= '0;
        else if (cmd.bin_wr)
            bin_mem[bin_addr] <= bin_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            scan_pend_reg <= 1'b0;
        end
        else
        begin
            scan_pend_reg <= cmd.scan_en;
            if (cmd.scan_en)
                scan_idx_reg <= status.scan_last ? '0 : scan_idx_reg + BW'(1);
        end
    end

    // winner search, lowest bin wins a tie
    logic [CW-1:0] best_cnt_reg;
    logic [SW-1:0] best_sum_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            best_cnt_reg <= '0;
        else if (scan_pend_reg && (bq[BWORD-1 -: CW] > best_cnt_reg))
        begin
            best_cnt_reg    <= bq[BWORD-1 -: CW];
            best_sum_reg[0] <= bq[SW-1:0];
            best_sum_reg[1] <= bq[2*SW-1 -: SW];
            best_sum_reg[2] <= bq[3*SW-1 -: SW];
        end
    end

    // restoring divider, one quotient bit per cycle on all three channels
    logic [SW-1:0]              drem_reg [0:2];
    logic [oilpm_pkg::PIX_W-1:0] dq_reg [0:2];
    logic [CW-1:0]              dcnt_reg;
    logic [2:0]                 step_reg;
    logic [DW-1:0]              trial;
    logic [DW-1:0]              diff [0:2];
    logic [2:0]                 hit;

    assign status.div_last = (step_reg == '0);

    always_comb
    begin
        trial = DW'(dcnt_reg) << step_reg;
        for (int i = 0; i < 3; i++)
        begin
            hit[i]  = (DW'(drem_reg[i]) >= trial);
            diff[i] = DW'(drem_reg[i]) - trial;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            dcnt_reg <= (best_cnt_reg == '0) ? CW'(1) : best_cnt_reg;
            step_reg <= 3'd7;
            for (int i = 0; i < 3; i++)
            begin
                drem_reg[i] <= best_sum_reg[i];
                dq_reg[i]   <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg - 3'd1;
            for (int i = 0; i < 3; i++)
            begin
                if (hit[i])
                    drem_reg[i] <= diff[i][SW-1:0];
                dq_reg[i] <= {dq_reg[i][oilpm_pkg::PIX_W-2:0], hit[i]};
            end
        end
    end

    // output word register
    logic out_valid_reg;

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_x      <= oilpm_pkg::X_W'(wc_reg - XW'(wrad_reg));
            out_y      <= wr_reg - 12'(wrad_reg);
            out_red    <= dq_reg[0];
            out_green  <= dq_reg[1];
            out_blue   <= dq_reg[2];
            frame_last <= wlast_reg;
        end
    end

endmodule

// File: dv/oilpm_checker.sv
// Scoreboard for the oil paint mode filter: tracks config, predicts each output word, compares.
module oilpm_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [oilpm_pkg::IDX_W-1:0] cfg_index,
    input  logic [oilpm_pkg::CFG_W-1:0] cfg_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [oilpm_pkg::PIX_W-1:0] in_red,
    input  logic [oilpm_pkg::PIX_W-1:0] in_green,
    input  logic [oilpm_pkg::PIX_W-1:0] in_blue,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [oilpm_pkg::X_W-1:0]   out_x,
    input  logic [oilpm_pkg::Y_W-1:0]   out_y,
    input  logic [oilpm_pkg::PIX_W-1:0] out_red,
    input  logic [oilpm_pkg::PIX_W-1:0] out_green,
    input  logic [oilpm_pkg::PIX_W-1:0] out_blue,
    input  logic                        frame_last,
    output int                          fails,
    output int                          pending,
    output int                          checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINES = 11;

    typedef struct packed {
        logic [oilpm_pkg::X_W-1:0]   x;
        logic [oilpm_pkg::Y_W-1:0]   y;
        logic [oilpm_pkg::PIX_W-1:0] r;
        logic [oilpm_pkg::PIX_W-1:0] g;
        logic [oilpm_pkg::PIX_W-1:0] b;
        logic                        last;
    } filt_word_t;

    logic [23:0]  lines [0:LINES-1][0:2047];
    int           col_cnt;
    int           row_cnt;
    logic [2:0]   cur_rad;
    logic [7:0]   cur_lev;
    logic [11:0]  cur_w;
    logic [12:0]  cur_h;
    filt_word_t   awaited [$];

    task automatic take_pixel(input logic [7:0] pr, input logic [7:0] pg,
                              input logic [7:0] pb);
        int w, h, rad, span, c, r, bin, best, best_n, n;
        int counts [256];
        int sums [256][3];
        logic [23:0] p;
        filt_word_t e;
        w = (cur_w == 0) ? 1 : ((cur_w > 2048) ? 2048 : int'(cur_w));
        h = (cur_h == 0) ? 1 :
            ((cur_h > oilpm_pkg::MAX_HEIGHT) ? oilpm_pkg::MAX_HEIGHT : int'(cur_h));
        rad = (cur_rad > 5) ? 5 : int'(cur_rad);
        span = 2 * rad;
        if (col_cnt >= w)
        begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h)
            row_cnt = 0;
        c = col_cnt;
        r = row_cnt;
        lines[r % LINES][c] = {pb, pg, pr};
        if (c >= span && r >= span)
        begin
            for (int i = 0; i < 256; i++)
            begin
                counts[i] = 0;
                sums[i][0] = 0;
                sums[i][1] = 0;
                sums[i][2] = 0;
            end
            for (int yy = r - span; yy <= r; yy++)
                for (int xx = c - span; xx <= c; xx++)
                begin
                    p = lines[yy % LINES][xx];
                    bin = ((int'(p[7:0]) + int'(p[15:8]) + int'(p[23:16]))
                           * int'(cur_lev)) / 765;
                    if (bin > 255)
                        bin = 255;
                    counts[bin]++;
                    sums[bin][0] += p[7:0];
                    sums[bin][1] += p[15:8];
                    sums[bin][2] += p[23:16];
                end
            best = 0;
            best_n = 0;
            for (int i = 0; i < 256; i++)
                if (counts[i] > best_n)
                begin
                    best_n = counts[i];
                    best = i;
                end
            n = (best_n != 0) ? best_n : 1;
            e.x = oilpm_pkg::X_W'(c - rad);
            e.y = oilpm_pkg::Y_W'(r - rad);
            e.r = oilpm_pkg::PIX_W'(sums[best][0] / n);
            e.g = oilpm_pkg::PIX_W'(sums[best][1] / n);
            e.b = oilpm_pkg::PIX_W'(sums[best][2] / n);
            e.last = (c == w - 1 && r == h - 1);
            awaited.push_back(e);
        end
        col_cnt++;
        if (col_cnt >= w)
        begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h)
                row_cnt = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        filt_word_t e;
        filt_word_t got;
        if (!rst_n)
        begin
            col_cnt = 0;
            row_cnt = 0;
            cur_rad = oilpm_pkg::RADIUS_RST;
            cur_lev = oilpm_pkg::LEVELS_RST;
            cur_w = oilpm_pkg::WIDTH_RST;
            cur_h = oilpm_pkg::HEIGHT_RST;
            awaited.delete();
            fails = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    oilpm_pkg::REG_RADIUS: cur_rad = cfg_data[2:0];
                    oilpm_pkg::REG_LEVELS: cur_lev = cfg_data[7:0];
                    oilpm_pkg::REG_WIDTH:  cur_w = cfg_data[11:0];
                    oilpm_pkg::REG_HEIGHT: cur_h = cfg_data[12:0];
                    default: ;
                endcase
            if (in_valid && in_ready)
                take_pixel(in_red, in_green, in_blue);
            if (out_valid && out_ready)
            begin
                got = '{out_x, out_y, out_red, out_green, out_blue, frame_last};
                checked++;
                if (awaited.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("ERROR: unexpected word x=%0d y=%0d", out_x, out_y);
                end
                else
                begin
                    e = awaited.pop_front();
                    if (got.x !== e.x || got.y !== e.y || got.r !== e.r || got.g !== e.g
                        || got.b !== e.b || got.last !== e.last)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display({"ERROR: exp x=%0d y=%0d rgb=%0d,%0d,%0d last=%0d",
                                      " got x=%0d y=%0d rgb=%0d,%0d,%0d last=%0d"},
                                     e.x, e.y, e.r, e.g, e.b, e.last,
                                     got.x, got.y, got.r, got.g, got.b, got.last);
                    end
                end
            end
            pending = awaited.size();
        end
    end
endmodule

// File: dv/tb.sv
// Testbench top for the oil paint mode filter: clock, reset, pixel frames, verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE = 1100;
    localparam int WATCHDOG = 20000;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [oilpm_pkg::IDX_W-1:0] cfg_index = oilpm_pkg::REG_RADIUS;
    logic [oilpm_pkg::CFG_W-1:0] cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [oilpm_pkg::PIX_W-1:0] in_red = '0;
    logic [oilpm_pkg::PIX_W-1:0] in_green = '0;
    logic [oilpm_pkg::PIX_W-1:0] in_blue = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [oilpm_pkg::X_W-1:0]   out_x;
    logic [oilpm_pkg::Y_W-1:0]   out_y;
    logic [oilpm_pkg::PIX_W-1:0] out_red;
    logic [oilpm_pkg::PIX_W-1:0] out_green;
    logic [oilpm_pkg::PIX_W-1:0] out_blue;
    logic                        frame_last;
    int                          fails;
    int                          pending;
    int                          checked;

    bit               burst = 1'b0;
    int               stall_left = 0;
    int               idle_cycles = 0;
    int               pixels_sent = 0;
    int               frames_run = 0;

    always #1 clk = ~clk;

    oil_paint_mode_filter DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .frame_last(frame_last)
    );

    oilpm_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .frame_last(frame_last),
        .fails(fails), .pending(pending), .checked(checked)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!burst && $urandom_range(0, 4) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > WATCHDOG)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_red <= r;
        in_green <= g;
        in_blue <= b;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        pixels_sent++;
        @(negedge clk);
    endtask

    // drains all expected words, then waits a further SETTLE period with no input
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_cfg(input int rad, input int lev, input int w, input int h);
        cfg_we <= 1'b1;
        cfg_index <= oilpm_pkg::REG_RADIUS;
        cfg_data <= oilpm_pkg::CFG_W'(rad);
        @(negedge clk);
        cfg_index <= oilpm_pkg::REG_LEVELS;
        cfg_data <= oilpm_pkg::CFG_W'(lev);
        @(negedge clk);
        cfg_index <= oilpm_pkg::REG_WIDTH;
        cfg_data <= oilpm_pkg::CFG_W'(w);
        @(negedge clk);
        cfg_index <= oilpm_pkg::REG_HEIGHT;
        cfg_data <= oilpm_pkg::CFG_W'(h);
        @(negedge clk);
        cfg_we <= 1'b0;
        frames_run++;
    endtask

    task automatic run_frame(input int count, input bit palette);
        logic [23:0] pal [4];
        logic [23:0] p;
        foreach (pal[i])
            pal[i] = 24'($urandom());
        for (int i = 0; i < count; i++)
        begin
            if (palette)
            begin
                p = pal[$urandom_range(0, 3)];
                if ($urandom_range(0, 9) == 0)
                    p[7:0] = p[7:0] ^ 8'($urandom_range(1, 7));
            end
            else
                p = 24'($urandom());
            send_pixel(p[7:0], p[15:8], p[23:16]);
        end
    endtask

    initial
    begin
        int rad, lev, w, h, er, lo, rand_items;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-pixel frame, zero radius: output is the pixel
        write_cfg(0, 255, 0, 0);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        settle();
        // zero levels, everything lands in bin 0
        write_cfg(0, 0, 3, 2);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'h55, 8'hAA, 8'h55);
        settle();
        write_cfg(1, 0, 3, 3);
        run_frame(9, 1'b0);
        settle();
        write_cfg(1, 255, 4, 4);
        run_frame(16, 1'b0);
        settle();
        // radius above max clamps to 5
        write_cfg(7, 1, 11, 11);
        run_frame(121, 1'b1);
        settle();
        // image too small for the window
        write_cfg(5, 128, 10, 11);
        run_frame(110, 1'b0);
        settle();
        // oversize width and height clamp
        write_cfg(1, 40, 4095, 1);
        run_frame(40, 1'b0);
        settle();
        write_cfg(2, 40, 1, 8191);
        run_frame(40, 1'b0);
        settle();
        // counters left beyond a shrunk width, then a shrunk height
        write_cfg(0, 7, 8, 3);
        run_frame(6, 1'b0);
        settle();
        write_cfg(0, 7, 4, 3);
        run_frame(3, 1'b0);
        settle();
        write_cfg(0, 7, 4, 1);
        run_frame(2, 1'b0);
        settle();
        write_cfg(0, 7, 1, 1);
        run_frame(1, 1'b0);
        settle();

        rand_items = 0;
        while (rand_items < 500)
        begin
            case ($urandom_range(0, 9))
                0: rad = 0;
                1, 2, 3: rad = 1;
                4, 5, 6: rad = 2;
                7: rad = 3;
                8: rad = 4;
                default: rad = $urandom_range(5, 7);
            endcase
            case ($urandom_range(0, 5))
                0: lev = 0;
                1: lev = 255;
                2: lev = 1;
                3: lev = $urandom_range(0, 255);
                default: lev = $urandom_range(1, 40);
            endcase
            er = (rad > 5) ? 5 : rad;
            lo = 2 * er + 1;
            if ($urandom_range(0, 7) == 0)
            begin
                w = $urandom_range(1, lo);
                h = $urandom_range(1, lo);
            end
            else
            begin
                w = lo + $urandom_range(0, 6);
                h = lo + $urandom_range(0, 4);
            end
            settle();
            burst = ($urandom_range(0, 3) == 0);
            write_cfg(rad, lev, w, h);
            run_frame(w * h, $urandom_range(0, 9) < 6);
            rand_items += w * h;
        end
        burst = 1'b0;
        settle();

        $display("run covered %0d pixels in %0d frame settings", pixels_sent, frames_run);
        $display("%0d filtered words checked, %0d mismatches", checked, fails);
        if (fails == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
